@@ hdl/plbl_pkg.sv @@
// Shared types and constants for the piecewise-linear bound lookup.
// Holds the transfer payload structs, the opcode and register codes and the FSM states.
// No dependencies.
package plbl_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int SLOT_BITS  = 4;
	localparam int COUNT_BITS = 5;
	localparam int WIDE_BITS  = ANGLE_BITS + 1;
	localparam int PROD_BITS  = 2 * WIDE_BITS;
	localparam int DIV_STEPS  = WIDE_BITS;
	localparam int STEP_BITS  = $clog2(DIV_STEPS);

	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;

	typedef logic signed [ANGLE_BITS-1:0] angle_t;
	typedef logic [WIDE_BITS-1:0] wide_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_ENTRY_COUNT = 1'b0;

	typedef struct packed {
		logic                 opcode;
		logic [SLOT_BITS-1:0] entry_index;
		angle_t               pan_angle;
		angle_t               lower_limit_in;
		angle_t               upper_limit_in;
	} item_t;

	typedef struct packed {
		logic   reachable;
		angle_t lower_tilt;
		angle_t upper_tilt;
	} result_t;

	typedef struct packed {
		angle_t pan;
		angle_t lower;
		angle_t upper;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_NEXT,
		ST_RESULT
	} state_t;

endpackage

@@ hdl/piecewise_linear_bound_lookup.sv @@
// Top level of the piecewise-linear bound lookup: breakpoint memory, scan FSM,
// shared multiply and restoring divide unit, result register and config port.
// Depends on plbl_pkg.
//
//  channel   | handshake               | payload          | role
//  ----------+-------------------------+------------------+-------------------------------
//  item      | item_valid / item_stall | plbl_pkg::item_t | load one breakpoint or query
//  result    | result_valid / stall    | result_t         | limits for one query
//  config    | APB psel/penable/...    | pwdata[4:0]      | entry_count register
//
// A load is written to the breakpoint memory at the edge of its transfer.
// A query scans the slots in order from slot 0 (one memory read per cycle through the
// single synchronous read port), then interpolates when the query pan falls between two
// slots; the lower and upper limits share one multiplier and one radix-2 divider, in turn.
// Reset clears the control state and entry_count; the memory holds no reset value.
// The output register lets a new item be taken while a result still waits on result_stall.
module piecewise_linear_bound_lookup #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  plbl_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output plbl_pkg::result_t                    result,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [plbl_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [plbl_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [plbl_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// Configuration register.
	logic [plbl_pkg::COUNT_BITS-1:0] entry_count_q;
	logic                            reg_sel;
	logic [CW-1:0]                   count;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[plbl_pkg::APB_ADDR_BITS-1] == plbl_pkg::REG_ENTRY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			entry_count_q <= pwdata[plbl_pkg::COUNT_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = plbl_pkg::APB_DATA_BITS'(entry_count_q);
		end
	end

	// Counts above the table depth are clamped to the depth.
	always_comb begin
		if (32'(entry_count_q) > MAX_ENTRIES) begin
			count = CW'(MAX_ENTRIES);
		end else begin
			count = CW'(entry_count_q);
		end
	end

	// Control and datapath registers.
	plbl_pkg::state_t state_q, state_d;

	logic                             item_xfer;
	logic                             is_query;
	logic                             slot_free;
	logic [IW-1:0]                    k_q;
	logic                             ch_q;
	logic [plbl_pkg::STEP_BITS-1:0]   step_q;
	plbl_pkg::angle_t                 q_pan_q;
	plbl_pkg::entry_t                 prev_q;
	plbl_pkg::entry_t                 end_q;
	plbl_pkg::wide_t                  num_q;
	plbl_pkg::wide_t                  den_q;
	plbl_pkg::wide_t                  rem_q;
	plbl_pkg::wide_t                  dvd_q;
	logic                             neg_q;
	logic                             reach_q;
	plbl_pkg::angle_t                 res_lo_q;
	plbl_pkg::angle_t                 res_hi_q;
	logic                             result_valid_q;
	plbl_pkg::result_t                result_q;

	// Breakpoint memory with one write port and one registered read port.
	plbl_pkg::entry_t mem [MAX_ENTRIES];
	plbl_pkg::entry_t rd_data_q;
	logic             mem_we;
	logic             mem_re;
	logic [IW-1:0]    wr_addr;
	logic [IW-1:0]    rd_addr;
	plbl_pkg::entry_t wr_data;

	assign item_xfer = item_valid && !item_stall;
	assign is_query  = (item.opcode == plbl_pkg::OP_QUERY);
	assign slot_free = !result_valid_q || !result_stall;

	assign wr_addr = IW'(item.entry_index);
	assign wr_data = '{pan: item.pan_angle, lower: item.lower_limit_in,
		upper: item.upper_limit_in};
	assign mem_we  = item_xfer && !is_query && (32'(item.entry_index) < MAX_ENTRIES);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Scan decisions on the entry that the memory returned this cycle.
	logic hit_ge;
	logic hit_eq;
	logic last_slot;

	assign hit_ge    = (rd_data_q.pan >= q_pan_q);
	assign hit_eq    = (rd_data_q.pan == q_pan_q);
	assign last_slot = (32'(k_q) == (32'(count) - 32'd1));

	logic div_last;
	assign div_last = (step_q == plbl_pkg::STEP_BITS'(plbl_pkg::DIV_STEPS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			plbl_pkg::ST_IDLE: begin
				if (item_xfer && is_query) begin
					state_d = (count == '0) ? plbl_pkg::ST_RESULT : plbl_pkg::ST_SCAN;
				end
			end
			plbl_pkg::ST_SCAN: begin
				if (hit_ge) begin
					if (hit_eq || (k_q == '0)) begin
						state_d = plbl_pkg::ST_RESULT;
					end else begin
						state_d = plbl_pkg::ST_MUL;
					end
				end else if (last_slot) begin
					state_d = plbl_pkg::ST_RESULT;
				end
			end
			plbl_pkg::ST_MUL: begin
				state_d = plbl_pkg::ST_DIV;
			end
			plbl_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = plbl_pkg::ST_NEXT;
				end
			end
			plbl_pkg::ST_NEXT: begin
				state_d = ch_q ? plbl_pkg::ST_RESULT : plbl_pkg::ST_MUL;
			end
			plbl_pkg::ST_RESULT: begin
				if (slot_free) begin
					state_d = plbl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plbl_pkg::ST_IDLE;
			end
		endcase
	end

	// FSM outputs: input stall and memory read control.
	always_comb begin
		item_stall = 1'b1;
		mem_re     = 1'b0;
		rd_addr    = '0;
		case (state_q)
			plbl_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				mem_re     = item_valid && is_query;
				rd_addr    = '0;
			end
			plbl_pkg::ST_SCAN: begin
				// Prefetch the following slot; a wrapped address is never used.
				mem_re  = 1'b1;
				rd_addr = k_q + IW'(1);
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plbl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Interpolation arithmetic for the channel in work (lower first, then upper).
	plbl_pkg::angle_t          ys;
	plbl_pkg::angle_t          ye;
	plbl_pkg::wide_t           dy;
	plbl_pkg::wide_t           mag;
	logic [plbl_pkg::PROD_BITS-1:0] prod;
	logic [plbl_pkg::WIDE_BITS:0]   trial;
	logic [plbl_pkg::WIDE_BITS:0]   trial_diff;
	plbl_pkg::wide_t           interp_val;

	assign ys   = ch_q ? prev_q.upper : prev_q.lower;
	assign ye   = ch_q ? end_q.upper : end_q.lower;
	assign dy   = {ye[plbl_pkg::ANGLE_BITS-1], ye} - {ys[plbl_pkg::ANGLE_BITS-1], ys};
	assign mag  = dy[plbl_pkg::WIDE_BITS-1] ? (~dy + 1'b1) : dy;
	assign prod = plbl_pkg::PROD_BITS'(mag) * plbl_pkg::PROD_BITS'(num_q);

	// One restoring-division step: the remainder stays below the divisor.
	assign trial      = {rem_q, dvd_q[plbl_pkg::WIDE_BITS-1]};
	assign trial_diff = trial - {1'b0, den_q};

	// The quotient sits in dvd_q once the divide is done; it never exceeds |dy|.
	assign interp_val = neg_q
		? ({ys[plbl_pkg::ANGLE_BITS-1], ys} - dvd_q)
		: ({ys[plbl_pkg::ANGLE_BITS-1], ys} + dvd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			ch_q   <= 1'b0;
			step_q <= '0;
		end else begin
			case (state_q)
				plbl_pkg::ST_IDLE: begin
					k_q  <= '0;
					ch_q <= 1'b0;
				end
				plbl_pkg::ST_SCAN: begin
					if (!hit_ge) begin
						k_q <= k_q + IW'(1);
					end
				end
				plbl_pkg::ST_MUL: begin
					step_q <= '0;
				end
				plbl_pkg::ST_DIV: begin
					step_q <= step_q + plbl_pkg::STEP_BITS'(1);
				end
				plbl_pkg::ST_NEXT: begin
					ch_q <= 1'b1;
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			plbl_pkg::ST_IDLE: begin
				if (item_xfer && is_query) begin
					q_pan_q  <= item.pan_angle;
					reach_q  <= 1'b0;
					res_lo_q <= '0;
					res_hi_q <= '0;
				end
			end
			plbl_pkg::ST_SCAN: begin
				if (hit_ge) begin
					if (hit_eq) begin
						reach_q  <= 1'b1;
						res_lo_q <= rd_data_q.lower;
						res_hi_q <= rd_data_q.upper;
					end
					end_q <= rd_data_q;
					num_q <= {q_pan_q[plbl_pkg::ANGLE_BITS-1], q_pan_q}
						- {prev_q.pan[plbl_pkg::ANGLE_BITS-1], prev_q.pan};
					den_q <= {rd_data_q.pan[plbl_pkg::ANGLE_BITS-1], rd_data_q.pan}
						- {prev_q.pan[plbl_pkg::ANGLE_BITS-1], prev_q.pan};
				end else begin
					prev_q <= rd_data_q;
				end
			end
			plbl_pkg::ST_MUL: begin
				// The product is below |dy| * den, so its upper half is below den.
				neg_q <= dy[plbl_pkg::WIDE_BITS-1];
				rem_q <= prod[plbl_pkg::PROD_BITS-1:plbl_pkg::WIDE_BITS];
				dvd_q <= prod[plbl_pkg::WIDE_BITS-1:0];
			end
			plbl_pkg::ST_DIV: begin
				if (!trial_diff[plbl_pkg::WIDE_BITS]) begin
					rem_q <= trial_diff[plbl_pkg::WIDE_BITS-1:0];
					dvd_q <= {dvd_q[plbl_pkg::WIDE_BITS-2:0], 1'b1};
				end else begin
					rem_q <= trial[plbl_pkg::WIDE_BITS-1:0];
					dvd_q <= {dvd_q[plbl_pkg::WIDE_BITS-2:0], 1'b0};
				end
			end
			plbl_pkg::ST_NEXT: begin
				reach_q <= 1'b1;
				if (ch_q) begin
					res_hi_q <= interp_val[plbl_pkg::ANGLE_BITS-1:0];
				end else begin
					res_lo_q <= interp_val[plbl_pkg::ANGLE_BITS-1:0];
				end
			end
			default: begin
				reach_q <= reach_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == plbl_pkg::ST_RESULT && slot_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == plbl_pkg::ST_RESULT && slot_free) begin
			result_q <= '{reachable: reach_q, lower_tilt: res_lo_q, upper_tilt: res_hi_q};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A new result is only presented after the result state has loaded it.
	a_result_from_fsm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == plbl_pkg::ST_RESULT))
		else $error("result presented without a finished query");

	// The divider remainder must stay below the divisor between steps.
	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plbl_pkg::ST_DIV |-> rem_q < den_q)
		else $error("divider remainder out of range");

	// The scan never looks past the last valid slot.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plbl_pkg::ST_SCAN |-> 32'(k_q) < 32'(count))
		else $error("scan index beyond entry count");

	// A load transfer leaves the block idle and produces no result.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer && !is_query |=> state_q == plbl_pkg::ST_IDLE)
		else $error("load transfer started a query");

endmodule
